// ----- hw/rtl/bpa_pkg.sv -----
`default_nettype none

package bpa_pkg;

   localparam int NUM_PAGES  = 16384;
   localparam int NUM_ORDERS = 11;
   localparam int PAGE_W     = 14;
   localparam int LINK_W     = 15;
   localparam int ORD_W      = 4;
   localparam int TOTAL_W    = 25;

   localparam logic [LINK_W-1:0] NIL_LINK  = LINK_W'(NUM_PAGES);
   localparam logic [ORD_W-1:0]  TOP_ORDER = ORD_W'(NUM_ORDERS - 1);

   localparam logic       OP_ALLOC = 1'b0;
   localparam logic       OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FAIL = 2'd1;
   localparam logic [1:0] ST_ZERO = 2'd2;

   localparam logic [1:0] REG_BASE  = 2'd0;
   localparam logic [1:0] REG_PAGES = 2'd1;

   // write side of the link store, one port per field array
   typedef struct packed {
      logic              flag_we;
      logic [PAGE_W-1:0] flag_addr;
      logic              flag_d;
      logic              ord_we;
      logic [PAGE_W-1:0] ord_addr;
      logic [ORD_W-1:0]  ord_d;
      logic              next_we;
      logic [PAGE_W-1:0] next_addr;
      logic [LINK_W-1:0] next_d;
      logic              prev_we;
      logic [PAGE_W-1:0] prev_addr;
      logic [LINK_W-1:0] prev_d;
   } link_wr_type;

   // registered read side
   typedef struct packed {
      logic              flag;
      logic [ORD_W-1:0]  ord;
      logic [LINK_W-1:0] next;
      logic [LINK_W-1:0] prev;
   } link_rd_type;

   // smallest order whose block holds cnt pages (0 .. 16)
   function automatic logic [4:0] ceil_order(input logic [15:0] cnt);
      logic [4:0] o;
      o = 5'd16;
      for (int i = 16; i >= 0; i--) begin
         if ((17'd1 << i) >= {1'b0, cnt}) begin
            o = 5'(i);
         end
      end
      return o;
   endfunction

   // largest order not above rem pages, capped at the top order
   function automatic logic [ORD_W-1:0] build_order(input logic [LINK_W-1:0] rem);
      logic [ORD_W-1:0] o;
      o = '0;
      for (int i = 1; i < NUM_ORDERS; i++) begin
         if ((16'd1 << i) <= {1'b0, rem}) begin
            o = ORD_W'(i);
         end
      end
      return o;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/buddy_page_allocator_top.sv -----
// an alloc searches the orders upward from the requested one, unlinks the head block and splits it down
// a free unlinks the block if it is on a free list, merges it with each free buddy of equal order, then pushes it
// one item at a time, set by the sequencer and the single read address of the link store
// reset and every write to the base or pages register start a flag clearing pass over all 16384 pages,
// then the region is built block by block onto the free lists; no item is taken meanwhile
// the result register lets a new item be accepted while a result waits
`default_nettype none

module buddy_page_allocator_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic        req_opcode,
   input  wire logic [15:0] req_page_count,
   input  wire logic [13:0] req_page_index,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [13:0]      rsp_block_index,
   output logic [14:0]      rsp_free_total,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [14:0] csr_wdata
);

   localparam logic [4:0] S_CLR   = 5'd0;
   localparam logic [4:0] S_BINI  = 5'd1;
   localparam logic [4:0] S_BLD   = 5'd2;
   localparam logic [4:0] S_IDLE  = 5'd3;
   localparam logic [4:0] S_DEC   = 5'd4;
   localparam logic [4:0] S_ASRCH = 5'd5;
   localparam logic [4:0] S_ASPL  = 5'd6;
   localparam logic [4:0] S_FRD   = 5'd7;
   localparam logic [4:0] S_FCHK  = 5'd8;
   localparam logic [4:0] S_FBRD  = 5'd9;
   localparam logic [4:0] S_FBCK  = 5'd10;
   localparam logic [4:0] S_FMRG  = 5'd11;
   localparam logic [4:0] S_PUSHA = 5'd12;
   localparam logic [4:0] S_PUSHB = 5'd13;
   localparam logic [4:0] S_URD   = 5'd14;
   localparam logic [4:0] S_UWR   = 5'd15;
   localparam logic [4:0] S_RESP  = 5'd16;

   localparam int PW = bpa_pkg::PAGE_W;
   localparam int LW = bpa_pkg::LINK_W;
   localparam int OW = bpa_pkg::ORD_W;
   localparam int TW = bpa_pkg::TOTAL_W;
   localparam int NO = bpa_pkg::NUM_ORDERS;

   logic [4:0]    state_ff, state_in, ret_ff, ret_in;
   logic          op_ff, op_in;
   logic [15:0]   cnt_ff, cnt_in;
   logic [PW-1:0] idx_ff, idx_in;
   logic [4:0]    ord_ff, ord_in;
   logic [OW-1:0] cur_ff, cur_in;
   logic [PW-1:0] blk_ff, blk_in;
   logic [1:0]    status_ff, status_in;
   logic [PW-1:0] res_ff, res_in;
   logic [PW-1:0] pidx_ff, pidx_in;
   logic [OW-1:0] pord_ff, pord_in;
   logic [LW-1:0] hh_ff, hh_in;
   logic [PW-1:0] uidx_ff, uidx_in;
   logic [PW-1:0] clr_ff, clr_in;
   logic [LW-1:0] bcur_ff, bcur_in, brem_ff, brem_in;
   logic [PW-1:0] base_ff, base_in;
   logic [LW-1:0] pages_ff, pages_in;
   logic [LW-1:0] head_ff [NO];
   logic [LW-1:0] head_in [NO];
   logic [LW-1:0] count_ff [NO];
   logic [LW-1:0] count_in [NO];
   logic [TW-1:0] total_ff, total_in;
   logic          rvalid_ff, rvalid_in;
   logic [1:0]    rstatus_ff, rstatus_in;
   logic [PW-1:0] rblock_ff, rblock_in;
   logic [LW-1:0] rtotal_ff, rtotal_in;

   bpa_pkg::link_wr_type wr;
   bpa_pkg::link_rd_type rd;
   logic [PW-1:0]        rd_addr;

   logic [15:0]   reg_end;
   logic [LW-1:0] end_clip;
   logic [OW-1:0] bord, ncur;
   logic [PW-1:0] buddy;
   logic [14:0]   fsum;
   logic [4:0]    dord;

   bpa_link_mem u_mem (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd      (rd)
   );

   assign csr_ready       = (state_ff == S_IDLE);
   assign req_stall       = (state_ff != S_IDLE) || csr_valid;
   assign rsp_valid       = rvalid_ff;
   assign rsp_status      = rstatus_ff;
   assign rsp_block_index = rblock_ff;
   assign rsp_free_total  = rtotal_ff;

   // shared helpers
   always_comb begin
      reg_end  = {2'b00, base_ff} + {1'b0, pages_ff};
      end_clip = (reg_end > 16'(bpa_pkg::NUM_PAGES)) ? bpa_pkg::NIL_LINK : reg_end[LW-1:0];
      bord     = bpa_pkg::build_order(brem_ff);
      ncur     = cur_ff - 1'b1;
      buddy    = idx_ff ^ (PW'(1) << ord_ff[OW-1:0]);
      fsum     = {1'b0, idx_ff} + (15'd1 << ord_ff[OW-1:0]);
      dord     = bpa_pkg::ceil_order(cnt_ff);
   end

   // sequencer
   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      op_in      = op_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      ord_in     = ord_ff;
      cur_in     = cur_ff;
      blk_in     = blk_ff;
      status_in  = status_ff;
      res_in     = res_ff;
      pidx_in    = pidx_ff;
      pord_in    = pord_ff;
      hh_in      = hh_ff;
      uidx_in    = uidx_ff;
      clr_in     = clr_ff;
      bcur_in    = bcur_ff;
      brem_in    = brem_ff;
      base_in    = base_ff;
      pages_in   = pages_ff;
      head_in    = head_ff;
      count_in   = count_ff;
      total_in   = total_ff;
      rvalid_in  = rvalid_ff && rsp_stall;
      rstatus_in = rstatus_ff;
      rblock_in  = rblock_ff;
      rtotal_in  = rtotal_ff;
      wr         = '0;
      rd_addr    = uidx_ff;

      unique case (state_ff)
         S_CLR: begin
            wr.flag_we   = 1'b1;
            wr.flag_addr = clr_ff;
            wr.flag_d    = 1'b0;
            clr_in       = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_BINI;
            end
         end
         S_BINI: begin
            bcur_in = {1'b0, base_ff};
            brem_in = end_clip - {1'b0, base_ff};
            state_in = ({1'b0, base_ff} >= end_clip) ? S_IDLE : S_BLD;
         end
         S_BLD: begin
            if (brem_ff == '0) begin
               state_in = S_IDLE;
            end else begin
               pidx_in  = bcur_ff[PW-1:0];
               pord_in  = bord;
               ret_in   = S_BLD;
               state_in = S_PUSHA;
               bcur_in  = bcur_ff + (LW'(1) << bord);
               brem_in  = brem_ff - (LW'(1) << bord);
            end
         end
         S_IDLE: begin
            if (csr_valid) begin
               if (csr_index == bpa_pkg::REG_BASE || csr_index == bpa_pkg::REG_PAGES) begin
                  if (csr_index == bpa_pkg::REG_BASE) begin
                     base_in = csr_wdata[PW-1:0];
                  end else begin
                     pages_in = csr_wdata;
                  end
                  for (int i = 0; i < NO; i++) begin
                     head_in[i]  = bpa_pkg::NIL_LINK;
                     count_in[i] = '0;
                  end
                  total_in = '0;
                  clr_in   = '0;
                  state_in = S_CLR;
               end
            end else if (req_valid) begin
               op_in    = req_opcode;
               cnt_in   = req_page_count;
               idx_in   = req_page_index;
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            ord_in = dord;
            res_in = '0;
            status_in = bpa_pkg::ST_OK;
            state_in = S_RESP;
            if (cnt_ff == '0) begin
               status_in = bpa_pkg::ST_ZERO;
            end else if (dord > 5'(bpa_pkg::TOP_ORDER)) begin
               status_in = bpa_pkg::ST_FAIL;
            end else if (op_ff == bpa_pkg::OP_ALLOC) begin
               cur_in   = dord[OW-1:0];
               state_in = S_ASRCH;
            end else begin
               state_in = S_FRD;
            end
         end
         S_ASRCH: begin
            if (cur_ff == OW'(NO)) begin
               status_in = bpa_pkg::ST_FAIL;
               state_in  = S_RESP;
            end else if (head_ff[cur_ff] != bpa_pkg::NIL_LINK) begin
               blk_in   = head_ff[cur_ff][PW-1:0];
               uidx_in  = head_ff[cur_ff][PW-1:0];
               ret_in   = S_ASPL;
               state_in = S_URD;
            end else begin
               cur_in = cur_ff + 1'b1;
            end
         end
         S_ASPL: begin
            if (cur_ff > ord_ff[OW-1:0]) begin
               cur_in   = ncur;
               pidx_in  = blk_ff + (PW'(1) << ncur);
               pord_in  = ncur;
               ret_in   = S_ASPL;
               state_in = S_PUSHA;
            end else begin
               res_in   = blk_ff;
               state_in = S_RESP;
            end
         end
         S_FRD: begin
            if (fsum > 15'(bpa_pkg::NUM_PAGES)) begin
               status_in = bpa_pkg::ST_FAIL;
               state_in  = S_RESP;
            end else begin
               rd_addr  = idx_ff;
               state_in = S_FCHK;
            end
         end
         S_FCHK: begin
            if (rd.flag) begin
               uidx_in  = idx_ff;
               ret_in   = S_FBRD;
               state_in = S_URD;
            end else begin
               state_in = S_FBRD;
            end
         end
         S_FBRD: begin
            if (ord_ff[OW-1:0] == bpa_pkg::TOP_ORDER) begin
               pidx_in  = idx_ff;
               pord_in  = ord_ff[OW-1:0];
               ret_in   = S_RESP;
               state_in = S_PUSHA;
            end else begin
               rd_addr  = buddy;
               state_in = S_FBCK;
            end
         end
         S_FBCK: begin
            if (rd.flag && rd.ord == ord_ff[OW-1:0]) begin
               uidx_in  = buddy;
               ret_in   = S_FMRG;
               state_in = S_URD;
            end else begin
               pidx_in  = idx_ff;
               pord_in  = ord_ff[OW-1:0];
               ret_in   = S_RESP;
               state_in = S_PUSHA;
            end
         end
         S_FMRG: begin
            idx_in   = idx_ff & ~(PW'(1) << ord_ff[OW-1:0]);
            ord_in   = ord_ff + 1'b1;
            state_in = S_FBRD;
         end
         S_PUSHA: begin
            wr.flag_we   = 1'b1;
            wr.flag_addr = pidx_ff;
            wr.flag_d    = 1'b1;
            wr.ord_we    = 1'b1;
            wr.ord_addr  = pidx_ff;
            wr.ord_d     = pord_ff;
            wr.next_we   = 1'b1;
            wr.next_addr = pidx_ff;
            wr.next_d    = head_ff[pord_ff];
            wr.prev_we   = 1'b1;
            wr.prev_addr = pidx_ff;
            wr.prev_d    = bpa_pkg::NIL_LINK;
            hh_in             = head_ff[pord_ff];
            head_in[pord_ff]  = {1'b0, pidx_ff};
            count_in[pord_ff] = count_ff[pord_ff] + 1'b1;
            total_in          = total_ff + (TW'(1) << pord_ff);
            state_in = (head_ff[pord_ff] != bpa_pkg::NIL_LINK) ? S_PUSHB : ret_ff;
         end
         S_PUSHB: begin
            wr.prev_we   = 1'b1;
            wr.prev_addr = hh_ff[PW-1:0];
            wr.prev_d    = {1'b0, pidx_ff};
            state_in     = ret_ff;
         end
         S_URD: begin
            rd_addr  = uidx_ff;
            state_in = S_UWR;
         end
         S_UWR: begin
            if (rd.prev != bpa_pkg::NIL_LINK) begin
               wr.next_we   = 1'b1;
               wr.next_addr = rd.prev[PW-1:0];
               wr.next_d    = rd.next;
            end else begin
               head_in[rd.ord] = rd.next;
            end
            if (rd.next != bpa_pkg::NIL_LINK) begin
               wr.prev_we   = 1'b1;
               wr.prev_addr = rd.next[PW-1:0];
               wr.prev_d    = rd.prev;
            end
            wr.flag_we   = 1'b1;
            wr.flag_addr = uidx_ff;
            wr.flag_d    = 1'b0;
            count_in[rd.ord] = count_ff[rd.ord] - 1'b1;
            total_in         = total_ff - (TW'(1) << rd.ord);
            state_in         = ret_ff;
         end
         S_RESP: begin
            if (!rvalid_ff || !rsp_stall) begin
               rvalid_in  = 1'b1;
               rstatus_in = status_ff;
               rblock_in  = res_ff;
               rtotal_in  = (total_ff > TW'(32767)) ? 15'h7FFF : total_ff[LW-1:0];
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLR;
         ret_ff    <= S_IDLE;
         clr_ff    <= '0;
         base_ff   <= '0;
         pages_ff  <= 15'd16384;
         total_ff  <= '0;
         rvalid_ff <= 1'b0;
         for (int i = 0; i < NO; i++) begin
            head_ff[i]  <= bpa_pkg::NIL_LINK;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         ret_ff    <= ret_in;
         clr_ff    <= clr_in;
         base_ff   <= base_in;
         pages_ff  <= pages_in;
         total_ff  <= total_in;
         rvalid_ff <= rvalid_in;
         head_ff   <= head_in;
         count_ff  <= count_in;
      end
      op_ff      <= op_in;
      cnt_ff     <= cnt_in;
      idx_ff     <= idx_in;
      ord_ff     <= ord_in;
      cur_ff     <= cur_in;
      blk_ff     <= blk_in;
      status_ff  <= status_in;
      res_ff     <= res_in;
      pidx_ff    <= pidx_in;
      pord_ff    <= pord_in;
      hh_ff      <= hh_in;
      uidx_ff    <= uidx_in;
      bcur_ff    <= bcur_in;
      brem_ff    <= brem_in;
      rstatus_ff <= rstatus_in;
      rblock_ff  <= rblock_in;
      rtotal_ff  <= rtotal_in;
   end

   // a new result only ever comes out of the response state
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      (!rvalid_ff || rsp_stall) ##1 rvalid_ff && !$past(rvalid_ff) |-> $past(state_ff == S_RESP))
      else $error("result raised outside response state");

   // splitting never goes below the requested order
   a_split: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ASPL) |-> (cur_ff >= ord_ff[OW-1:0]))
      else $error("split below requested order");

   // an accepted item goes straight to decode
   a_decode: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == S_DEC))
      else $error("accepted beat not decoded");

endmodule

`default_nettype wire

// ----- hw/rtl/bpa_link_mem.sv -----
`default_nettype none

module bpa_link_mem (
   input  wire logic                       clock,
   input  wire bpa_pkg::link_wr_type       wr,
   input  wire logic [bpa_pkg::PAGE_W-1:0] rd_addr,
   output bpa_pkg::link_rd_type            rd
);

   logic                         flag_mem [bpa_pkg::NUM_PAGES];
   logic [bpa_pkg::ORD_W-1:0]    ord_mem  [bpa_pkg::NUM_PAGES];
   logic [bpa_pkg::LINK_W-1:0]   next_mem [bpa_pkg::NUM_PAGES];
   logic [bpa_pkg::LINK_W-1:0]   prev_mem [bpa_pkg::NUM_PAGES];

   // one write per field array, one shared read address, registered read data
   always_ff @(posedge clock) begin
      if (wr.flag_we) begin
         flag_mem[wr.flag_addr] <= wr.flag_d;
      end
      if (wr.ord_we) begin
         ord_mem[wr.ord_addr] <= wr.ord_d;
      end
      if (wr.next_we) begin
         next_mem[wr.next_addr] <= wr.next_d;
      end
      if (wr.prev_we) begin
         prev_mem[wr.prev_addr] <= wr.prev_d;
      end
      rd.flag <= flag_mem[rd_addr];
      rd.ord  <= ord_mem[rd_addr];
      rd.next <= next_mem[rd_addr];
      rd.prev <= prev_mem[rd_addr];
   end

endmodule

`default_nettype wire
